// ===== hw/rtl/midpoint_round_rect_raster_unit_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the midpoint round-rect raster unit.
// The macros expect signals named clk and rst_n in the module that uses them.
// ---------------------------------------------------------------------------
`ifndef MIDPOINT_ROUND_RECT_RASTER_UNIT_MACROS_SVH
`define MIDPOINT_ROUND_RECT_RASTER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MRR_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// The consequent must hold in the cycle after the antecedent.
`define MRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/mrr_pkg.sv =====
// ---------------------------------------------------------------------------
// mrr_pkg
// Shared types and constants of the midpoint round-rect raster unit.
// ---------------------------------------------------------------------------
package mrr_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int SIZE_W     = 15;
    localparam int SCALE_W    = 5;
    localparam int DIV_STEPS  = SIZE_W;
    localparam int COORD_BITS = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WIN_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_BOTTOM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd4;

    localparam logic KIND_START = 1'b0;

    typedef enum logic [1:0] {
        ELONG_ROUND,
        ELONG_WIDE,
        ELONG_TALL
    } elong_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK_WIN,
        ST_DIVIDE,
        ST_SETUP,
        ST_MUL,
        ST_EMIT,
        ST_UPDATE,
        ST_STATUS
    } state_t;

    typedef struct packed {
        logic       load_start;
        logic       div_init;
        logic       div_step;
        logic       setup;
        logic       mul;
        logic       emit;
        logic       emit_status;
        logic       update;
        logic       lines;
        logic       last;
        logic       fin;
        logic [2:0] idx;
    } cmd_t;

    typedef struct packed {
        logic reject;
        logic zero;
        logic round;
        logic four;
        logic final_step;
        logic busy;
        logic out_free;
    } sts_t;

endpackage

// ===== hw/rtl/mrr_ctrl.sv =====
// ---------------------------------------------------------------------------
// mrr_ctrl
// Sequencer: accepts items, runs the divider and steps through the results.
// ---------------------------------------------------------------------------
`include "midpoint_round_rect_raster_unit_macros.svh"

module mrr_ctrl
    import mrr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    input  logic kind,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t     state_reg, state_next;
    logic [2:0] idx_reg, idx_next;
    logic       lines_reg, lines_next;
    logic       fin_reg, fin_next;
    logic [3:0] cnt_reg, cnt_next;
    logic [2:0] last_idx;
    logic       accept;

    assign accept   = s_tvalid && s_tready;
    assign last_idx = lines_reg ? 3'd1 : (sts.four ? 3'd3 : 3'd7);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            lines_reg <= 1'b0;
            fin_reg   <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            lines_reg <= lines_next;
            fin_reg   <= fin_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and sequencing counters.
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        lines_next = lines_reg;
        fin_next   = fin_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (kind == KIND_START)
                    begin
                        state_next = ST_CHECK_WIN;
                    end
                    else if (sts.busy)
                    begin
                        state_next = ST_MUL;
                        idx_next   = '0;
                        lines_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_STATUS;
                        fin_next   = 1'b1;
                    end
                end
            end
            ST_CHECK_WIN:
            begin
                if (sts.reject)
                begin
                    state_next = ST_STATUS;
                    fin_next   = 1'b1;
                end
                else
                begin
                    state_next = ST_DIVIDE;
                    cnt_next   = '0;
                end
            end
            ST_DIVIDE:
            begin
                if (cnt_reg == 4'(DIV_STEPS - 1))
                begin
                    state_next = ST_SETUP;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            ST_SETUP:
            begin
                if (sts.zero)
                begin
                    state_next = ST_STATUS;
                    fin_next   = 1'b1;
                end
                else if (sts.round)
                begin
                    state_next = ST_STATUS;
                    fin_next   = 1'b0;
                end
                else
                begin
                    state_next = ST_MUL;
                    idx_next   = '0;
                    lines_next = 1'b1;
                end
            end
            ST_MUL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    if (idx_reg == last_idx)
                    begin
                        state_next = lines_reg ? ST_IDLE : ST_UPDATE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 3'd1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            ST_STATUS:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        s_tready        = (state_reg == ST_IDLE);
        cmd             = '0;
        cmd.idx         = idx_reg;
        cmd.lines       = lines_reg;
        cmd.load_start  = accept && (kind == KIND_START);
        cmd.div_init    = (state_reg == ST_CHECK_WIN) && !sts.reject;
        cmd.div_step    = (state_reg == ST_DIVIDE);
        cmd.setup       = (state_reg == ST_SETUP) && !sts.zero;
        cmd.mul         = (state_reg == ST_MUL);
        cmd.emit        = (state_reg == ST_EMIT) && sts.out_free;
        cmd.emit_status = (state_reg == ST_STATUS) && sts.out_free;
        cmd.update      = (state_reg == ST_UPDATE);
        if (state_reg == ST_STATUS)
        begin
            cmd.last = 1'b1;
            cmd.fin  = fin_reg;
        end
        else
        begin
            cmd.last = (idx_reg == last_idx);
            cmd.fin  = !lines_reg && sts.final_step;
        end
    end

    `MRR_ASSERT_NEXT(a_accept_starts_work, s_tvalid && s_tready, state_reg != ST_IDLE)
    `MRR_ASSERT_IMPL(a_idx_in_range, state_reg == ST_MUL || state_reg == ST_EMIT, idx_reg <= last_idx)
    `MRR_ASSERT_NEXT(a_divide_begins, cmd.div_init, state_reg == ST_DIVIDE && cnt_reg == 4'd0)

endmodule

// ===== hw/rtl/mrr_datapath.sv =====
// ---------------------------------------------------------------------------
// mrr_datapath
// Window and scale registers, shape state, divider, offset scaling and the
// output register.
// ---------------------------------------------------------------------------
module mrr_datapath
    import mrr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic [63:0]          s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,
    output logic [1:0]           m_tuser,
    output logic                 m_tlast,
    input  cmd_t                 cmd,
    output sts_t                 sts
);

    localparam int WW = 34;

    logic signed [15:0] win_left_reg, win_right_reg, win_top_reg, win_bottom_reg;
    logic [SCALE_W-1:0] scale_reg;

    logic signed [15:0] cx_reg, cy_reg;
    logic               fill_reg;
    logic [SIZE_W-1:0]  xs_reg, ys_reg;
    logic [SIZE_W-1:0]  qx_reg, qy_reg;
    logic [5:0]         rx_reg, ry_reg;
    logic [SIZE_W-1:0]  stretch_reg;
    elong_t             elong_reg;
    logic signed [15:0] step_x_reg, step_y_reg;
    logic signed [19:0] err_reg, inc_u_reg, inc_v_reg;
    logic               busy_reg;
    logic signed [23:0] prod_reg [4];
    logic               out_valid_reg;
    logic [63:0]        out_data_reg;
    logic [1:0]         out_user_reg;
    logic               out_last_reg;

    logic [SCALE_W-1:0] eff_scale;
    logic signed [17:0] cx_e, cy_e, xs_e, ys_e;
    logic [SIZE_W-1:0]  rad, gap;
    logic signed [19:0] inc_u_next, inc_v_next, err_next;
    logic signed [15:0] step_x_next, step_y_next;
    logic signed [17:0] dx, dy, dd, ex, ey;
    logic signed [17:0] off [4];
    logic signed [23:0] prod_next [4];
    logic signed [WW-1:0] x0w, y0w, x1w, y1w;
    logic               vis;
    logic [6:0]         div_x, div_y;

    function automatic logic signed [WW-1:0] wrap(input logic signed [15:0] c,
                                                  input logic signed [23:0] p);
        logic signed [WW-1:0] e;
        e = WW'(c) + WW'(p);
        return (e <<< (WW - COORD_BITS)) >>> (WW - COORD_BITS);
    endfunction

    assign cfg_ready = 1'b1;
    assign eff_scale = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;

    // Window rejection on the unscaled box.
    assign cx_e = 18'(cx_reg);
    assign cy_e = 18'(cy_reg);
    assign xs_e = 18'(xs_reg);
    assign ys_e = 18'(ys_reg);

    assign rad = (qx_reg < qy_reg) ? qx_reg : qy_reg;
    assign gap = (qx_reg > qy_reg) ? (qx_reg - qy_reg) : (qy_reg - qx_reg);

    // One restoring division step per lane.
    assign div_x = {rx_reg, qx_reg[SIZE_W-1]};
    assign div_y = {ry_reg, qy_reg[SIZE_W-1]};

    // Midpoint step.
    always_comb
    begin
        inc_u_next  = inc_u_reg + 20'sd2;
        step_x_next = step_x_reg + 16'sd1;
        if (err_reg < 0)
        begin
            inc_v_next  = inc_v_reg + 20'sd2;
            err_next    = err_reg + inc_u_next;
            step_y_next = step_y_reg;
        end
        else
        begin
            inc_v_next  = inc_v_reg + 20'sd4;
            err_next    = err_reg + inc_v_next;
            step_y_next = step_y_reg - 16'sd1;
        end
    end

    // Offsets of the current result, in raster steps from the centre.
    always_comb
    begin
        dx = 18'(step_x_reg);
        dy = 18'(step_y_reg);
        dd = 18'(stretch_reg);
        ex = '0;
        ey = '0;
        for (int i = 0; i < 4; i++)
        begin
            off[i] = '0;
        end
        if (cmd.lines)
        begin
            if (elong_reg == ELONG_WIDE)
            begin
                off[0] = -dd;
                off[2] = dd;
                off[1] = cmd.idx[0] ? dy : -dy;
                off[3] = off[1];
            end
            else
            begin
                off[0] = cmd.idx[0] ? dy : -dy;
                off[2] = off[0];
                off[1] = -dd;
                off[3] = dd;
            end
        end
        else if (fill_reg)
        begin
            if (elong_reg == ELONG_WIDE)
            begin
                ex = cmd.idx[2] ? dd : -dd;
            end
            else if (elong_reg == ELONG_TALL)
            begin
                ey = cmd.idx[2] ? dd : -dd;
            end
            case (cmd.idx[1:0])
                2'd0:
                begin
                    off[0] = ex - dx; off[2] = ex + dx;
                    off[1] = ey - dy; off[3] = ey - dy;
                end
                2'd1:
                begin
                    off[0] = ex - dx; off[2] = ex + dx;
                    off[1] = ey + dy; off[3] = ey + dy;
                end
                2'd2:
                begin
                    off[0] = ex - dy; off[2] = ex + dy;
                    off[1] = ey - dx; off[3] = ey - dx;
                end
                default:
                begin
                    off[0] = ex - dy; off[2] = ex + dy;
                    off[1] = ey + dx; off[3] = ey + dx;
                end
            endcase
        end
        else
        begin
            if (elong_reg == ELONG_TALL)
            begin
                // Tall shapes go left/right first, then top/bottom halves.
                off[0] = cmd.idx[1] ? (cmd.idx[0] ? dy : dx) : (cmd.idx[0] ? -dy : -dx);
                off[1] = cmd.idx[0] ? dx + dd : dy + dd;
                if (!cmd.idx[2])
                begin
                    off[1] = -off[1];
                end
            end
            else
            begin
                off[0] = cmd.idx[0] ? dy : dx;
                off[1] = cmd.idx[0] ? dx : dy;
                if (elong_reg == ELONG_WIDE)
                begin
                    off[0] = off[0] + dd;
                end
                if (!cmd.idx[2])
                begin
                    off[0] = -off[0];
                end
                if (!cmd.idx[1])
                begin
                    off[1] = -off[1];
                end
            end
            off[2] = off[0];
            off[3] = off[1];
        end
        for (int i = 0; i < 4; i++)
        begin
            prod_next[i] = 24'(off[i]) * 24'(signed'({1'b0, eff_scale}));
        end
    end

    assign x0w = wrap(cx_reg, prod_reg[0]);
    assign y0w = wrap(cy_reg, prod_reg[1]);
    assign x1w = wrap(cx_reg, prod_reg[2]);
    assign y1w = wrap(cy_reg, prod_reg[3]);
    assign vis = cmd.lines || fill_reg ||
                 (x0w >= WW'(win_left_reg) && x0w <= WW'(win_right_reg) &&
                  y0w >= WW'(win_top_reg) && y0w <= WW'(win_bottom_reg));

    always_comb
    begin
        sts.reject = (cx_e - xs_e > 18'(win_right_reg)) ||
                     (cx_e + xs_e < 18'(win_left_reg)) ||
                     (cy_e - ys_e > 18'(win_bottom_reg)) ||
                     (cy_e + ys_e < 18'(win_top_reg));
        sts.zero       = (qx_reg == '0) || (qy_reg == '0);
        sts.round      = (qx_reg == qy_reg);
        sts.four       = fill_reg && (elong_reg == ELONG_ROUND);
        sts.final_step = step_x_next > step_y_next;
        sts.busy       = busy_reg;
        sts.out_free   = !out_valid_reg || m_tready;
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_left_reg   <= 16'sd0;
            win_right_reg  <= 16'sd32767;
            win_top_reg    <= 16'sd0;
            win_bottom_reg <= 16'sd32767;
            scale_reg      <= SCALE_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_WIN_LEFT:   win_left_reg   <= cfg_data;
                REG_WIN_RIGHT:  win_right_reg  <= cfg_data;
                REG_WIN_TOP:    win_top_reg    <= cfg_data;
                REG_WIN_BOTTOM: win_bottom_reg <= cfg_data;
                REG_SCALE:      scale_reg      <= cfg_data[SCALE_W-1:0];
                default:        ;
            endcase
        end
    end

    // Shape state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg      <= '0;
            cy_reg      <= '0;
            fill_reg    <= 1'b0;
            stretch_reg <= '0;
            elong_reg   <= ELONG_ROUND;
            step_x_reg  <= '0;
            step_y_reg  <= '0;
            err_reg     <= '0;
            inc_u_reg   <= '0;
            inc_v_reg   <= '0;
            busy_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.load_start)
            begin
                cx_reg   <= s_tdata[15:0];
                cy_reg   <= s_tdata[31:16];
                fill_reg <= s_tdata[62];
                busy_reg <= 1'b0;
            end
            if (cmd.setup)
            begin
                stretch_reg <= gap;
                elong_reg   <= (qx_reg == qy_reg) ? ELONG_ROUND :
                               ((qx_reg > qy_reg) ? ELONG_WIDE : ELONG_TALL);
                step_x_reg  <= '0;
                step_y_reg  <= 16'(rad);
                err_reg     <= 20'sd1 - 20'(rad);
                inc_u_reg   <= 20'sd1;
                inc_v_reg   <= 20'sd1 - (20'(rad) <<< 1);
                busy_reg    <= 1'b1;
            end
            if (cmd.update)
            begin
                step_x_reg <= step_x_next;
                step_y_reg <= step_y_next;
                err_reg    <= err_next;
                inc_u_reg  <= inc_u_next;
                inc_v_reg  <= inc_v_next;
                if (step_x_next > step_y_next)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Divider lanes and products; payload only.
    always_ff @(posedge clk)
    begin
        if (cmd.load_start)
        begin
            xs_reg <= s_tdata[46:32];
            ys_reg <= s_tdata[61:47];
        end
        if (cmd.div_init)
        begin
            qx_reg <= xs_reg;
            qy_reg <= ys_reg;
            rx_reg <= '0;
            ry_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_x >= 7'(eff_scale))
            begin
                rx_reg <= 6'(div_x - 7'(eff_scale));
                qx_reg <= {qx_reg[SIZE_W-2:0], 1'b1};
            end
            else
            begin
                rx_reg <= div_x[5:0];
                qx_reg <= {qx_reg[SIZE_W-2:0], 1'b0};
            end
            if (div_y >= 7'(eff_scale))
            begin
                ry_reg <= 6'(div_y - 7'(eff_scale));
                qy_reg <= {qy_reg[SIZE_W-2:0], 1'b1};
            end
            else
            begin
                ry_reg <= div_y[5:0];
                qy_reg <= {qy_reg[SIZE_W-2:0], 1'b0};
            end
        end
        if (cmd.mul)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_reg[i] <= prod_next[i];
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit || cmd.emit_status)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_data_reg <= {y1w[15:0], x1w[15:0], y0w[15:0], x0w[15:0]};
            out_user_reg <= {cmd.fin, vis};
            out_last_reg <= cmd.last;
        end
        else if (cmd.emit_status)
        begin
            out_data_reg <= '0;
            out_user_reg <= {cmd.fin, 1'b0};
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== hw/rtl/midpoint_round_rect_raster_unit.sv =====
// ---------------------------------------------------------------------------
// midpoint_round_rect_raster_unit
// Midpoint rasterizer for circles and stadium-shaped rounded rectangles.
// ---------------------------------------------------------------------------
// A start transfer (tuser 0) latches the centre, checks the unscaled box
// against the clip window, then divides both half sizes by the scale in two
// restoring divider lanes that run side by side; it ends with a single
// status result (round shape, rejected shape, or zero size) or with the two
// straight edge lines of an elongated shape. A step transfer (tuser 1)
// advances the midpoint walk by one step and gives eight octant points, or
// four or eight horizontal spans in fill mode; with no shape under way it
// gives a finished status result instead. Each result passes through the
// scale multipliers and then the centre adders and window compare. One item
// is worked on at a time; the next transfer is taken once the last result
// sits in the output register (and, for a step, the walk has been updated),
// even while that result waits for the sink. Window and scale registers may
// be written at any time the unit is idle; the write channel is always ready.
// ---------------------------------------------------------------------------
module midpoint_round_rect_raster_unit
    import mrr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Register write channel.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    // Item input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [63:0]          s_tdata,   // center_x, center_y, size_x, size_y, fill_mode, pad
    input  logic                 s_tuser,   // kind
    // Result output stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,   // seg_x0, seg_y0, seg_x1, seg_y1
    output logic [1:0]           m_tuser,   // visible, finished
    output logic                 m_tlast    // last
);

    cmd_t cmd;
    sts_t sts;

    // The sequencer owns the input handshake and tells the datapath what to
    // do each cycle; the datapath reports window, divider and walk status.
    mrr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .sts      (sts),
        .cmd      (cmd)
    );

    mrr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ===== sim/mrr_checker.sv =====
// ---------------------------------------------------------------------------
// mrr_checker
// Watches the register, item and result channels of the raster unit. It
// predicts the segments that each accepted item produces and compares them
// field by field with the result transfers, in order.
// ---------------------------------------------------------------------------
module mrr_checker
    import mrr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [63:0]          s_tdata,
    input  logic                 s_tuser,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [63:0]          m_tdata,
    input  logic [1:0]           m_tuser,
    input  logic                 m_tlast,
    output int                   errors,
    output int                   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] x0, y0, x1, y1;
        logic        vis, fin, lst;
    } seg_t;

    seg_t segs_due[$];

    // Window and scale as the unit holds them.
    logic signed [15:0] win_l, win_r, win_t, win_b;
    logic [4:0]         scl;

    // Shape and midpoint walk.
    int     ctr_x, ctr_y, strch;
    elong_t shape;
    logic   fill_on, active;
    int     walk_x, walk_y, err_acc, inc_a, inc_b;

    assign pending = segs_due.size();

    function automatic longint eff_scale();
        return (scl == 0) ? 1 : longint'(scl);
    endfunction

    task automatic push_seg(longint x0, longint y0, longint x1, longint y1, logic vis);
        seg_t s;
        s.x0 = x0[15:0]; s.y0 = y0[15:0]; s.x1 = x1[15:0]; s.y1 = y1[15:0];
        s.vis = vis; s.fin = 1'b0; s.lst = 1'b0;
        segs_due.push_back(s);
    endtask

    task automatic push_status(logic fin);
        seg_t s;
        s = '{x0: 0, y0: 0, x1: 0, y1: 0, vis: 0, fin: fin, lst: 1};
        segs_due.push_back(s);
    endtask

    task automatic push_point(longint ox, longint oy);
        logic signed [15:0] px, py;
        longint             fx, fy;
        fx = ctr_x + ox * eff_scale();
        fy = ctr_y + oy * eff_scale();
        px = fx[15:0];
        py = fy[15:0];
        push_seg(fx, fy, fx, fy, px >= win_l && px <= win_r && py >= win_t && py <= win_b);
    endtask

    // Four horizontal spans of one circle quarter set around (cx, cy).
    task automatic push_spans(longint cx, longint cy, longint dx, longint dy);
        dx = dx * eff_scale();
        dy = dy * eff_scale();
        push_seg(cx - dx, cy - dy, cx + dx, cy - dy, 1);
        push_seg(cx - dx, cy + dy, cx + dx, cy + dy, 1);
        push_seg(cx - dy, cy - dx, cx + dy, cy - dx, 1);
        push_seg(cx - dy, cy + dx, cx + dy, cy + dx, 1);
    endtask

    task automatic predict_segments(logic kind, logic [63:0] d);
        longint cx, cy, xs, ys, s, rad, gap, dx, dy, dd, ds;
        int     first;
        first = segs_due.size();
        s = eff_scale();
        if (kind == KIND_START) begin
            cx = longint'($signed(d[15:0]));
            cy = longint'($signed(d[31:16]));
            xs = longint'(d[46:32]);
            ys = longint'(d[61:47]);
            ctr_x = int'(cx);
            ctr_y = int'(cy);
            fill_on = d[62];
            active = 1'b0;
            if (cx - xs > win_r || cx + xs < win_l || cy - ys > win_b || cy + ys < win_t) begin
                push_status(1);
                return;
            end
            xs = xs / s;
            ys = ys / s;
            if (xs == 0 || ys == 0) begin
                push_status(1);
                return;
            end
            rad = (xs < ys) ? xs : ys;
            gap = (xs > ys) ? xs - ys : ys - xs;
            strch = int'(gap);
            shape = (xs == ys) ? ELONG_ROUND : ((xs > ys) ? ELONG_WIDE : ELONG_TALL);
            walk_x = 0;
            walk_y = int'(rad);
            err_acc = int'(1 - rad);
            inc_a = 1;
            inc_b = int'(1 - 2 * rad);
            active = 1'b1;
            if (shape == ELONG_ROUND) begin
                push_status(0);
                return;
            end
            // Elongated shapes start with their two straight edges.
            if (shape == ELONG_WIDE) begin
                push_seg(cx - gap * s, cy - rad * s, cx + gap * s, cy - rad * s, 1);
                push_seg(cx - gap * s, cy + rad * s, cx + gap * s, cy + rad * s, 1);
            end else begin
                push_seg(cx - rad * s, cy - gap * s, cx - rad * s, cy + gap * s, 1);
                push_seg(cx + rad * s, cy - gap * s, cx + rad * s, cy + gap * s, 1);
            end
            segs_due[$].lst = 1'b1;
            return;
        end

        if (!active || walk_x > walk_y) begin
            active = 1'b0;
            push_status(1);
            return;
        end
        dx = walk_x;
        dy = walk_y;
        dd = strch;
        ds = dd * s;
        if (!fill_on) begin
            case (shape)
                ELONG_ROUND: begin
                    push_point(-dx, -dy); push_point(-dy, -dx);
                    push_point(-dx, dy);  push_point(-dy, dx);
                    push_point(dx, -dy);  push_point(dy, -dx);
                    push_point(dx, dy);   push_point(dy, dx);
                end
                ELONG_WIDE: begin
                    push_point(-dx - dd, -dy); push_point(-dy - dd, -dx);
                    push_point(-dx - dd, dy);  push_point(-dy - dd, dx);
                    push_point(dx + dd, -dy);  push_point(dy + dd, -dx);
                    push_point(dx + dd, dy);   push_point(dy + dd, dx);
                end
                default: begin
                    push_point(-dx, -dy - dd); push_point(-dy, -dx - dd);
                    push_point(dx, -dy - dd);  push_point(dy, -dx - dd);
                    push_point(-dx, dy + dd);  push_point(-dy, dx + dd);
                    push_point(dx, dy + dd);   push_point(dy, dx + dd);
                end
            endcase
        end else if (shape == ELONG_ROUND) begin
            push_spans(ctr_x, ctr_y, dx, dy);
        end else if (shape == ELONG_WIDE) begin
            push_spans(ctr_x - ds, ctr_y, dx, dy);
            push_spans(ctr_x + ds, ctr_y, dx, dy);
        end else begin
            push_spans(ctr_x, ctr_y - ds, dx, dy);
            push_spans(ctr_x, ctr_y + ds, dx, dy);
        end
        inc_a += 2;
        if (err_acc < 0) begin
            inc_b += 2;
            err_acc += inc_a;
        end else begin
            inc_b += 4;
            err_acc += inc_b;
            walk_y--;
        end
        walk_x++;
        if (walk_x > walk_y) begin
            active = 1'b0;
            for (int i = first; i < segs_due.size(); i++)
                segs_due[i].fin = 1'b1;
        end
        segs_due[$].lst = 1'b1;
    endtask

    always @(posedge clk or negedge rst_n) begin
        seg_t want;
        if (!rst_n) begin
            win_l = 0; win_r = 16'sd32767; win_t = 0; win_b = 16'sd32767;
            scl = 5'd1;
            ctr_x = 0; ctr_y = 0; strch = 0; shape = ELONG_ROUND; fill_on = 0;
            walk_x = 0; walk_y = 0; err_acc = 0; inc_a = 0; inc_b = 0;
            active = 0;
            errors = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WIN_LEFT:   win_l = cfg_data;
                    REG_WIN_RIGHT:  win_r = cfg_data;
                    REG_WIN_TOP:    win_t = cfg_data;
                    REG_WIN_BOTTOM: win_b = cfg_data;
                    REG_SCALE:      scl = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_segments(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (segs_due.size() == 0) begin
                    $display("%0t: unexpected result: tdata %h tuser %b tlast %b",
                             $time, m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    want = segs_due.pop_front();
                    if (m_tdata !== {want.y1, want.x1, want.y0, want.x0}
                        || m_tuser !== {want.fin, want.vis} || m_tlast !== want.lst) begin
                        $display("%0t: mismatch: expected x0 %0d y0 %0d x1 %0d y1 %0d vis %b fin %b last %b",
                                 $time, $signed(want.x0), $signed(want.y0), $signed(want.x1),
                                 $signed(want.y1), want.vis, want.fin, want.lst);
                        $display("%0t:           actual x0 %0d y0 %0d x1 %0d y1 %0d vis %b fin %b last %b",
                                 $time, $signed(m_tdata[15:0]), $signed(m_tdata[31:16]),
                                 $signed(m_tdata[47:32]), $signed(m_tdata[63:48]),
                                 m_tuser[0], m_tuser[1], m_tlast);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the midpoint round-rect raster unit.
// ---------------------------------------------------------------------------
// A short directed sequence covers the special cases: a step with no shape,
// rejected and zero-size starts, extreme coordinates that wrap, round shapes
// in both modes, a filled wide and an outlined tall shape, and a start that
// abandons a busy shape. Then several phases, each with its own window and
// scale, send mostly complete shapes (a start followed by more steps than it
// needs to finish) mixed with random noise items. Both stream sides idle at
// random; the checker beside the unit predicts and compares every result.
// ---------------------------------------------------------------------------
module tb_top
    import mrr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_STEP   = ~KIND_START;
    localparam int   CYCLE_LIMIT = 1000000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0]          cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [63:0]          s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [63:0]          m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;

    int errors;
    int pending;
    int send_idle_pct;
    int sink_idle_pct;
    int cycles;

    // Window of the current phase; shapes are placed around it.
    int win_lo_x, win_hi_x, win_lo_y, win_hi_y, cur_scale;

    midpoint_round_rect_raster_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    mrr_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // The sink stalls at random at the rate of the current phase.
    always @(posedge clk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Guard against a hung unit.
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // One register write; the unit must be idle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[15:0];
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One item transfer. Before it the sender idles cycle by cycle at the
    // rate of the current phase; otherwise valid stays high into the next item.
    task automatic send_item(logic kind, int cx, int cy, int sx, int sy, logic fill);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, fill, sy[14:0], sx[14:0], cy[15:0], cx[15:0]};
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_step();
        send_item(KIND_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
    endtask

    // Wait until every result has arrived, then leave time for a start
    // still in its divider.
    task automatic drain();
        @(posedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    // A complete shape: start, then rad + 2 steps, which run past the end of the walk.
    // Gives back the number of items sent.
    task automatic shape_run(output int count);
        int rad, strch, elong, sx, sy, cx, cy, eff;
        eff = (cur_scale == 0) ? 1 : cur_scale;
        rad = $urandom_range(1, 12);
        strch = $urandom_range(1, 10);
        elong = $urandom_range(2);
        sx = rad * eff + $urandom_range(eff - 1);
        sy = rad * eff + $urandom_range(eff - 1);
        if (elong == 1) sx += strch * eff;
        if (elong == 2) sy += strch * eff;
        cx = $urandom_range(win_hi_x - win_lo_x + 40) + win_lo_x - 20;
        cy = $urandom_range(win_hi_y - win_lo_y + 40) + win_lo_y - 20;
        send_item(KIND_START, cx, cy, sx, sy, $urandom_range(1));
        repeat (rad + 2) send_step();
        count = rad + 3;
    endtask

    task automatic run_phase(int left, int right, int top, int bottom, int scl, int items);
        int sent, n;
        drain();
        write_reg(REG_WIN_LEFT, left);
        write_reg(REG_WIN_RIGHT, right);
        write_reg(REG_WIN_TOP, top);
        write_reg(REG_WIN_BOTTOM, bottom);
        write_reg(REG_SCALE, scl);
        win_lo_x = left; win_hi_x = right; win_lo_y = top; win_hi_y = bottom;
        cur_scale = scl;
        if (win_hi_x - win_lo_x > 2000) begin win_lo_x = -500; win_hi_x = 500; end
        if (win_hi_y - win_lo_y > 2000) begin win_lo_y = -500; win_hi_y = 500; end
        sent = 0;
        while (sent < items) begin
            if ($urandom_range(99) < 80) begin
                shape_run(n);
                sent += n;
            end else begin
                // Noise: a start with fully random fields, or a lone step.
                if ($urandom_range(1))
                    send_item(KIND_START, $urandom, $urandom, $urandom, $urandom,
                              $urandom_range(1));
                else
                    send_step();
                sent++;
            end
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_WIN_LEFT;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_START;
        m_tready  = 1'b0;
        send_idle_pct = 7;
        sink_idle_pct = 55;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset window and scale.
        send_step();                                            // no shape yet
        send_item(KIND_START, -100, 50, 5, 5, 0);               // box left of window
        send_item(KIND_START, 50, 50, 0, 7, 0);                 // zero half size
        send_item(KIND_START, 32767, 32767, 32767, 32767, 1);   // extremes, wraps
        send_step();
        send_step();
        send_item(KIND_START, -32768, -32768, 32767, 32767, 0); // opposite corner
        send_step();
        send_item(KIND_START, 20, 20, 3, 3, 0);                 // round outline
        repeat (4) send_step();
        send_item(KIND_START, 10, 30, 6, 2, 1);                 // wide, filled
        repeat (3) send_step();
        send_item(KIND_START, 2, 2, 2, 5, 0);                   // tall, clipped points
        send_step();
        send_item(KIND_START, 40, 40, 4, 4, 1);                 // abandons tall shape
        repeat (2) send_step();

        // Random phases with changing window and scale, extremes included.
        run_phase(-200, 200, -150, 150, 1, 60);
        run_phase(-32768, 32767, -32768, 32767, 16, 60);
        send_idle_pct = 55;
        sink_idle_pct = 7;
        run_phase(0, 300, -300, 0, 0, 60);
        run_phase(-50, 60, -70, 40, 31, 50);
        send_idle_pct = 0;
        sink_idle_pct = 0;
        run_phase(100, -100, 100, -100, 3, 50);                 // empty window
        run_phase(-300, 300, -300, 300, 2, 60);

        drain();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
